FILE: rtl/core/four_wheel_drive_mixer_core_assert.svh
// ----------------------------------------------------------------------------
// Four wheel drive mixer assertion macros
// Shared property forms for the mixer core checks.
// ----------------------------------------------------------------------------
`ifndef FOUR_WHEEL_DRIVE_MIXER_CORE_ASSERT_SVH
`define FOUR_WHEEL_DRIVE_MIXER_CORE_ASSERT_SVH

// same-cycle implication
`define FWDM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FWDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/fwdm_pkg.sv
// ----------------------------------------------------------------------------
// Four wheel drive mixer package
// Direction codes, command codes, power limits and the per-wheel slew function.
// ----------------------------------------------------------------------------
package fwdm_pkg;

    localparam int NUM_WHEELS  = 4;
    localparam int POWER_W     = 9;
    localparam int TARGET_W    = 11;
    localparam int MAG_W       = 10;

    localparam logic [POWER_W-1:0] POWER_MAX  = 9'd382;
    localparam logic [POWER_W-1:0] RAMP_RESET = 9'd511;

    localparam logic [9:0] LEVEL_LOW  = 10'd200;
    localparam logic [9:0] LEVEL_MID  = 10'd300;
    localparam logic [9:0] LEVEL_HIGH = 10'd400;

    localparam logic [7:0] TURN_LOW   = 8'd30;
    localparam logic [7:0] TURN_MID   = 8'd50;
    localparam logic [7:0] TURN_HIGH  = 8'd70;
    localparam logic [7:0] TURN_MAX   = 8'd100;

    typedef enum logic [2:0] {
        DIR_FORWARD  = 3'd0,
        DIR_BACKWARD = 3'd1,
        DIR_LEFT     = 3'd2,
        DIR_RIGHT    = 3'd3,
        DIR_START    = 3'd4,
        DIR_STOP     = 3'd5
    } dir_t;

    typedef enum logic {
        CMD_DRIVE      = 1'b0,
        CMD_CORRECTION = 1'b1
    } cmd_t;

    typedef enum logic {
        STATUS_OK          = 1'b0,
        STATUS_NOT_STARTED = 1'b1
    } status_t;

    typedef struct packed {
        logic [POWER_W-1:0] power;
        logic               reverse;
    } wheel_t;

    function automatic wheel_t wheel_slew(
        input logic signed [TARGET_W-1:0] target,
        input logic        [POWER_W-1:0]  prev,
        input logic        [POWER_W-1:0]  ramp,
        input logic                       rev_in
    );
        logic [TARGET_W-1:0] mag_full;
        logic [MAG_W-1:0]    mag;
        logic [MAG_W-1:0]    limit;
        wheel_t              res;
        res.reverse = rev_in;
        if (target < 0)
        begin
            mag_full    = TARGET_W'(-target);
            res.reverse = ~rev_in;
        end
        else
        begin
            mag_full = TARGET_W'(target);
        end
        mag   = mag_full[MAG_W-1:0];
        limit = {1'b0, prev} + {1'b0, ramp};
        if (mag > limit)
            mag = limit;
        if (mag > {1'b0, POWER_MAX})
            mag = {1'b0, POWER_MAX};
        res.power = mag[POWER_W-1:0];
        return res;
    endfunction

endpackage

FILE: rtl/core/four_wheel_drive_mixer_core.sv
// The result is registered: out_valid rises in the cycle after acceptance.
// Throughput: one request per cycle while out_ready is high; the wheel state
// and the result register update at the same edge, so a request that follows
// at once sees the new state. Reset: started clear, all wheel powers zero and
// forward, ramp limit 511, no result pending.
// ----------------------------------------------------------------------------
// Four wheel drive mixer core
// Mixes straight and turn power into four slew-limited wheel commands.
// ----------------------------------------------------------------------------
`include "four_wheel_drive_mixer_core_assert.svh"

module four_wheel_drive_mixer_core
    import fwdm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [POWER_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [2:0]         straight_dir,
    input  logic [7:0]         straight_power,
    input  logic [2:0]         turn_dir,
    input  logic [7:0]         turn_power,
    input  logic [9:0]         correction_level,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               status,
    output logic               motors_updated,
    output logic [POWER_W-1:0] front_left_power,
    output logic [POWER_W-1:0] front_right_power,
    output logic [POWER_W-1:0] rear_left_power,
    output logic [POWER_W-1:0] rear_right_power,
    output logic               front_left_reverse,
    output logic               front_right_reverse,
    output logic               rear_left_reverse,
    output logic               rear_right_reverse
);

    logic [POWER_W-1:0] ramp_limit_reg;
    logic               started_reg, started_next;
    logic               out_valid_reg;
    logic               status_reg, status_next;
    logic               updated_reg, updated_next;
    logic [POWER_W-1:0] wheel_power_reg [NUM_WHEELS];
    logic               wheel_reverse_reg [NUM_WHEELS];
    wheel_t             wheel_next [NUM_WHEELS];

    logic                       accept;
    logic [7:0]                 corr_turn;
    logic [POWER_W-1:0]         mix_spow;
    logic [7:0]                 mix_tpow;
    logic                       mix_rev;
    logic [6:0]                 half;
    logic signed [TARGET_W-1:0] sum_plus;
    logic signed [TARGET_W-1:0] sum_minus;
    logic signed [TARGET_W-1:0] target;
    logic                       do_mix;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        if (correction_level < LEVEL_LOW)
            corr_turn = TURN_LOW;
        else if (correction_level < LEVEL_MID)
            corr_turn = TURN_MID;
        else if (correction_level < LEVEL_HIGH)
            corr_turn = TURN_HIGH;
        else
            corr_turn = TURN_MAX;

        if (command == CMD_CORRECTION)
        begin
            mix_spow = wheel_power_reg[0];
            mix_tpow = corr_turn;
            mix_rev  = wheel_reverse_reg[0];
        end
        else
        begin
            mix_spow = {1'b0, straight_power};
            mix_tpow = turn_power;
            mix_rev  = (straight_dir == DIR_BACKWARD);
        end

        half      = mix_tpow[7:1];
        sum_plus  = $signed({2'b00, mix_spow}) + $signed({4'b0000, half});
        sum_minus = $signed({2'b00, mix_spow}) - $signed({4'b0000, half});

        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            target = $signed({2'b00, wheel_power_reg[i[1:0]]});
            if (mix_tpow != 8'd0)
            begin
                if (turn_dir == DIR_LEFT)
                    target = i[0] ? sum_plus : sum_minus;
                else if (turn_dir == DIR_RIGHT)
                    target = i[0] ? sum_minus : sum_plus;
            end
            else
            begin
                target = $signed({2'b00, mix_spow});
            end
            wheel_next[i[1:0]] = wheel_slew(target, wheel_power_reg[i[1:0]],
                                            ramp_limit_reg, mix_rev);
        end

        started_next = started_reg;
        status_next  = STATUS_OK;
        do_mix       = 1'b0;
        if (command == CMD_CORRECTION)
        begin
            do_mix = 1'b1;
        end
        else if (!started_reg)
        begin
            if (straight_dir == DIR_START)
                started_next = 1'b1;
            else
                status_next = STATUS_NOT_STARTED;
        end
        else if (straight_dir == DIR_STOP)
        begin
            started_next = 1'b0;
        end
        else
        begin
            do_mix = 1'b1;
        end
        updated_next = do_mix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ramp_limit_reg <= RAMP_RESET;
        else if (cfg_we)
            ramp_limit_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            status_reg    <= STATUS_OK;
            updated_reg   <= 1'b0;
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                wheel_power_reg[i[1:0]]   <= '0;
                wheel_reverse_reg[i[1:0]] <= 1'b0;
            end
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                started_reg   <= started_next;
                status_reg    <= status_next;
                updated_reg   <= updated_next;
                if (do_mix)
                begin
                    for (int i = 0; i < NUM_WHEELS; i++)
                    begin
                        wheel_power_reg[i[1:0]]   <= wheel_next[i[1:0]].power;
                        wheel_reverse_reg[i[1:0]] <= wheel_next[i[1:0]].reverse;
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign status              = status_reg;
    assign motors_updated      = updated_reg;
    assign front_left_power    = wheel_power_reg[0];
    assign front_right_power   = wheel_power_reg[1];
    assign rear_left_power     = wheel_power_reg[2];
    assign rear_right_power    = wheel_power_reg[3];
    assign front_left_reverse  = wheel_reverse_reg[0];
    assign front_right_reverse = wheel_reverse_reg[1];
    assign rear_left_reverse   = wheel_reverse_reg[2];
    assign rear_right_reverse  = wheel_reverse_reg[3];

    `FWDM_ASSERT_NEXT(a_not_started, clk, rst_n,
        accept && command == CMD_DRIVE && !started_reg && straight_dir != DIR_START,
        status_reg == STATUS_NOT_STARTED && !updated_reg && out_valid_reg,
        "drive request before start must report not started")

    `FWDM_ASSERT_NEXT(a_correction_mixes, clk, rst_n,
        accept && command == CMD_CORRECTION,
        updated_reg && status_reg == STATUS_OK && out_valid_reg,
        "correction request must update the wheels")

    `FWDM_ASSERT_NEXT(a_hold_wheels, clk, rst_n,
        !(accept && do_mix),
        $stable(front_left_power) && $stable(rear_right_power),
        "wheel state changed without a mixing request")

    `FWDM_ASSERT_NOW(a_power_range, clk, rst_n,
        out_valid_reg,
        front_left_power <= POWER_MAX && front_right_power <= POWER_MAX &&
        rear_left_power <= POWER_MAX && rear_right_power <= POWER_MAX,
        "wheel power above saturation limit")

endmodule
